// ===== rtl/core/free_list_insert_coalesce_assert.svh =====
// Assertion macros for the free list port checker.
`ifndef FREE_LIST_INSERT_COALESCE_ASSERT_SVH
`define FREE_LIST_INSERT_COALESCE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define FLCI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define FLCI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/flci_pkg.sv =====
// Types and constants of the free list insert and coalesce block.
package flci_pkg;

    localparam int FIELD_W   = 32;
    localparam int INDEX_W   = 4;
    localparam int COUNT_W   = 5;
    localparam int ORDER_W   = 3;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_INSERT_ORDER = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MERGE_ENABLE = 1'd1;

    localparam logic [ORDER_W-1:0] ORD_BACK     = 3'd0;
    localparam logic [ORDER_W-1:0] ORD_FRONT    = 3'd1;
    localparam logic [ORDER_W-1:0] ORD_BASE_UP  = 3'd2;
    localparam logic [ORDER_W-1:0] ORD_SIZE_UP  = 3'd3;
    localparam logic [ORDER_W-1:0] ORD_SIZE_DN  = 3'd4;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_INSERT,
        CELL_SCAN,
        CELL_MERGE,
        CELL_COMMIT
    } t_cell_op;

    typedef struct packed {
        t_cell_op             op;
        logic [ORDER_W-1:0]   order;
    } t_cell_ctl;

endpackage

// ===== rtl/core/flci_chunk_if.sv =====
// Channel carrying one freed chunk.
interface flci_chunk_if;
    logic                         valid;
    logic                         ready;
    logic [flci_pkg::FIELD_W-1:0] chunk_base;
    logic [flci_pkg::FIELD_W-1:0] chunk_size;

    modport source(output valid, chunk_base, chunk_size, input ready);
    modport sink(input valid, chunk_base, chunk_size, output ready);
endinterface

// ===== rtl/core/flci_entry_if.sv =====
// Channel carrying one free list entry of a list dump.
interface flci_entry_if;
    logic                         valid;
    logic                         ready;
    logic [flci_pkg::FIELD_W-1:0] entry_base;
    logic [flci_pkg::FIELD_W-1:0] entry_size;
    logic [flci_pkg::INDEX_W-1:0] entry_index;
    logic [flci_pkg::COUNT_W-1:0] entry_count;
    logic                         dropped;
    logic                         last_entry;

    modport source(output valid, entry_base, entry_size, entry_index, entry_count,
                   dropped, last_entry, input ready);
    modport sink(input valid, entry_base, entry_size, entry_index, entry_count,
                 dropped, last_entry, output ready);
endinterface

// ===== rtl/core/flci_cell.sv =====
// One list slot: working and committed base/size with insert, merge and compare logic.
module flci_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5,
    parameter int NW  = 5,
    parameter int AW  = 32
) (
    input  logic                i_clk,
    input  flci_pkg::t_cell_ctl i_ctl,
    input  logic [CW-1:0]       i_pos,
    input  logic [CW-1:0]       i_tgt,
    input  logic [CW-1:0]       i_self,
    input  logic [NW-1:0]       i_count,
    input  logic [AW-1:0]       i_key_base,
    input  logic [AW-1:0]       i_key_size,
    input  logic [AW-1:0]       i_sum,
    input  logic [AW-1:0]       i_left_base,
    input  logic [AW-1:0]       i_left_size,
    input  logic [AW-1:0]       i_right_base,
    input  logic [AW-1:0]       i_right_size,
    output logic [AW-1:0]       o_wbase,
    output logic [AW-1:0]       o_wsize,
    output logic [AW-1:0]       o_cbase,
    output logic [AW-1:0]       o_csize,
    output logic                o_less,
    output logic                o_touch
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);
    localparam logic [NW-1:0] MY_CNT = NW'(IDX);

    logic [AW-1:0] r_wbase, n_wbase;
    logic [AW-1:0] r_wsize, n_wsize;
    logic [AW-1:0] r_cbase, n_cbase;
    logic [AW-1:0] r_csize, n_csize;
    logic          r_touch, n_touch;

    always_comb begin
        case (i_ctl.order)
            flci_pkg::ORD_BASE_UP: o_less = r_wbase < i_key_base;
            flci_pkg::ORD_SIZE_UP: o_less = r_wsize < i_key_size;
            flci_pkg::ORD_SIZE_DN: o_less = r_wsize > i_key_size;
            default:               o_less = 1'b0;
        endcase
    end

    always_comb begin
        n_wbase = r_wbase;
        n_wsize = r_wsize;
        n_cbase = r_cbase;
        n_csize = r_csize;
        n_touch = r_touch;
        unique case (i_ctl.op)
            flci_pkg::CELL_LOAD: begin
                n_wbase = r_cbase;
                n_wsize = r_csize;
            end
            flci_pkg::CELL_INSERT: begin
                if (MY_IDX == i_pos) begin
                    n_wbase = i_key_base;
                    n_wsize = i_key_size;
                end else if (MY_IDX > i_pos) begin
                    n_wbase = i_left_base;
                    n_wsize = i_left_size;
                end
            end
            flci_pkg::CELL_SCAN: begin
                n_touch = (MY_IDX != i_self) && (MY_CNT < i_count) &&
                          (r_wbase >= i_key_base) &&
                          ((r_wbase - i_key_base) == i_key_size);
            end
            flci_pkg::CELL_MERGE: begin
                // absorbed slot at i_pos closes up; survivor lands at i_tgt
                if (MY_IDX == i_tgt) begin
                    n_wbase = i_key_base;
                    n_wsize = i_sum;
                end else if (MY_IDX >= i_pos) begin
                    n_wbase = i_right_base;
                    n_wsize = i_right_size;
                end
            end
            flci_pkg::CELL_COMMIT: begin
                n_cbase = r_wbase;
                n_csize = r_wsize;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_wbase <= n_wbase;
        r_wsize <= n_wsize;
        r_cbase <= n_cbase;
        r_csize <= n_csize;
        r_touch <= n_touch;
    end

    assign o_wbase = r_wbase;
    assign o_wsize = r_wsize;
    assign o_cbase = r_cbase;
    assign o_csize = r_csize;
    assign o_touch = r_touch;

endmodule

// ===== rtl/core/free_list_insert_coalesce.sv =====
// Free list insert and coalesce: top level with sequencer and row of list cells.
// After the transfer it loads, places and inserts; with merging on, the merge scan
// visits each slot, merges touching slots and ends; it commits, then sends one entry
// a cycle while the output is not stalled. The merge scan over the cell row is serial,
// and no new free is taken until the dump of the last one ends.
// Reset (synchronous, active low) empties the list, clears both registers to 0.
module free_list_insert_coalesce #(
    parameter int TABLE_DEPTH = 16,
    parameter int ADDR_WIDTH  = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_we,
    input  logic [flci_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [flci_pkg::CFG_W-1:0]            i_cfg_data,
    flci_chunk_if.sink                            i_chunk,
    flci_entry_if.source                          o_entry
);

    localparam int NC = TABLE_DEPTH + 1;
    localparam int CW = $clog2(NC);
    localparam int NW = $clog2(NC + 1);
    localparam int AW = ADDR_WIDTH;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_LOAD   = 9'b000000010,
        S_FIND   = 9'b000000100,
        S_INSERT = 9'b000001000,
        S_SCAN   = 9'b000010000,
        S_PICK   = 9'b000100000,
        S_APPLY  = 9'b001000000,
        S_DECIDE = 9'b010000000,
        S_DUMP   = 9'b100000000
    } t_state;

    t_state                          r_state, n_state;
    logic [flci_pkg::ORDER_W-1:0]    r_order;
    logic                            r_merge;
    logic [NW-1:0]                   r_len, n_len;
    logic [NW-1:0]                   r_wn, n_wn;
    logic [NW-1:0]                   r_mi, n_mi;
    logic [CW-1:0]                   r_pos, n_pos;
    logic [CW-1:0]                   r_j, n_j;
    logic [CW-1:0]                   r_didx, n_didx;
    logic                            r_drop, n_drop;
    logic [AW-1:0]                   r_cb, r_cs;
    logic                            r_ovalid, n_ovalid;
    logic                            out_load;
    logic [flci_pkg::FIELD_W-1:0]    r_obase, r_osize;
    logic [flci_pkg::INDEX_W-1:0]    r_oidx;
    logic [flci_pkg::COUNT_W-1:0]    r_ocnt;
    logic                            r_odrop, r_olast;

    logic [AW-1:0]   w_wbase [NC];
    logic [AW-1:0]   w_wsize [NC];
    logic [AW-1:0]   w_cbase [NC];
    logic [AW-1:0]   w_csize [NC];
    logic [NC-1:0]   w_less;
    logic [NC-1:0]   w_touch;

    flci_pkg::t_cell_ctl cell_ctl;
    logic [CW-1:0]   cell_pos, cell_tgt;
    logic [AW-1:0]   key_base, key_size, bcast_base, bcast_size, sum_val;
    logic [AW:0]     sum_full;
    logic [CW-1:0]   find_pos, pick_j;
    logic            in_xfer, dump_last;

    assign in_xfer        = i_chunk.valid && i_chunk.ready;
    assign i_chunk.ready  = (r_state == S_IDLE);

    assign bcast_base = w_wbase[r_mi[CW-1:0]];
    assign bcast_size = w_wsize[r_mi[CW-1:0]];
    assign sum_full   = {1'b0, bcast_size} + {1'b0, w_wsize[r_j]};
    assign sum_val    = sum_full[AW] ? '1 : sum_full[AW-1:0];

    assign key_base = (r_state == S_FIND || r_state == S_INSERT) ? r_cb : bcast_base;
    assign key_size = (r_state == S_FIND || r_state == S_INSERT) ? r_cs : bcast_size;
    assign cell_pos = (r_state == S_APPLY) ? r_j : r_pos;
    assign cell_tgt = (NW'(r_j) < r_mi) ? (r_mi[CW-1:0] - CW'(1)) : r_mi[CW-1:0];

    always_comb begin
        cell_ctl.order = r_order;
        cell_ctl.op    = flci_pkg::CELL_HOLD;
        unique case (r_state)
            S_LOAD:   cell_ctl.op = flci_pkg::CELL_LOAD;
            S_INSERT: cell_ctl.op = flci_pkg::CELL_INSERT;
            S_SCAN:   if (r_mi < r_wn) cell_ctl.op = flci_pkg::CELL_SCAN;
            S_APPLY:  cell_ctl.op = flci_pkg::CELL_MERGE;
            S_DECIDE: if (r_wn <= NW'(TABLE_DEPTH)) cell_ctl.op = flci_pkg::CELL_COMMIT;
            default:  cell_ctl.op = flci_pkg::CELL_HOLD;
        endcase
    end

    // sorted orders insert before the first live slot not less than the chunk
    always_comb begin
        find_pos = r_wn[CW-1:0];
        if (r_order == flci_pkg::ORD_FRONT) begin
            find_pos = '0;
        end else if (r_order == flci_pkg::ORD_BASE_UP || r_order == flci_pkg::ORD_SIZE_UP ||
                     r_order == flci_pkg::ORD_SIZE_DN) begin
            for (int k = NC - 1; k >= 0; k--) begin
                if (NW'(k) < r_wn && !w_less[k]) find_pos = CW'(k);
            end
        end
    end

    always_comb begin
        pick_j = '0;
        for (int k = NC - 1; k >= 0; k--) begin
            if (w_touch[k]) pick_j = CW'(k);
        end
    end

    assign out_load  = (r_state == S_DUMP) && (!r_ovalid || o_entry.ready);
    assign dump_last = (NW'(r_didx) + NW'(1)) == r_len;

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_wn     = r_wn;
        n_mi     = r_mi;
        n_pos    = r_pos;
        n_j      = r_j;
        n_didx   = r_didx;
        n_drop   = r_drop;
        n_ovalid = r_ovalid;
        if (o_entry.ready) n_ovalid = 1'b0;
        if (out_load)      n_ovalid = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_LOAD;
            end
            S_LOAD: begin
                n_wn    = r_len;
                n_state = S_FIND;
            end
            S_FIND: begin
                n_pos   = find_pos;
                n_state = S_INSERT;
            end
            S_INSERT: begin
                n_wn    = r_wn + NW'(1);
                n_mi    = '0;
                n_state = r_merge ? S_SCAN : S_DECIDE;
            end
            S_SCAN: begin
                n_state = (r_mi < r_wn) ? S_PICK : S_DECIDE;
            end
            S_PICK: begin
                if (|w_touch) begin
                    n_j     = pick_j;
                    n_state = S_APPLY;
                end else begin
                    n_mi    = r_mi + NW'(1);
                    n_state = S_SCAN;
                end
            end
            S_APPLY: begin
                n_wn    = r_wn - NW'(1);
                n_mi    = NW'(cell_tgt);
                n_state = S_SCAN;
            end
            S_DECIDE: begin
                n_drop = r_wn > NW'(TABLE_DEPTH);
                if (r_wn <= NW'(TABLE_DEPTH)) n_len = r_wn;
                n_didx  = '0;
                n_state = S_DUMP;
            end
            S_DUMP: begin
                if (out_load) begin
                    n_didx = r_didx + CW'(1);
                    if (dump_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_order  <= flci_pkg::ORD_BACK;
            r_merge  <= 1'b0;
            r_len    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_len    <= n_len;
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    flci_pkg::REG_INSERT_ORDER: r_order <= i_cfg_data;
                    flci_pkg::REG_MERGE_ENABLE: r_merge <= i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wn   <= n_wn;
        r_mi   <= n_mi;
        r_pos  <= n_pos;
        r_j    <= n_j;
        r_didx <= n_didx;
        r_drop <= n_drop;
        if (in_xfer) begin
            r_cb <= AW'(i_chunk.chunk_base);
            r_cs <= AW'(i_chunk.chunk_size);
        end
        if (out_load) begin
            r_obase <= flci_pkg::FIELD_W'(w_cbase[r_didx]);
            r_osize <= flci_pkg::FIELD_W'(w_csize[r_didx]);
            r_oidx  <= flci_pkg::INDEX_W'(r_didx);
            r_ocnt  <= flci_pkg::COUNT_W'(r_len);
            r_odrop <= r_drop;
            r_olast <= dump_last;
        end
    end

    assign o_entry.valid       = r_ovalid;
    assign o_entry.entry_base  = r_obase;
    assign o_entry.entry_size  = r_osize;
    assign o_entry.entry_index = r_oidx;
    assign o_entry.entry_count = r_ocnt;
    assign o_entry.dropped     = r_odrop;
    assign o_entry.last_entry  = r_olast;

    for (genvar k = 0; k < NC; k++) begin : g_cell
        logic [AW-1:0] lb, ls, rb, rs;
        if (k == 0) begin : g_first
            assign lb = '0;
            assign ls = '0;
        end else begin : g_mid
            assign lb = w_wbase[k-1];
            assign ls = w_wsize[k-1];
        end
        if (k == NC - 1) begin : g_last
            assign rb = '0;
            assign rs = '0;
        end else begin : g_inner
            assign rb = w_wbase[k+1];
            assign rs = w_wsize[k+1];
        end

        flci_cell #(
            .IDX (k),
            .CW  (CW),
            .NW  (NW),
            .AW  (AW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (cell_ctl),
            .i_pos        (cell_pos),
            .i_tgt        (cell_tgt),
            .i_self       (r_mi[CW-1:0]),
            .i_count      (r_wn),
            .i_key_base   (key_base),
            .i_key_size   (key_size),
            .i_sum        (sum_val),
            .i_left_base  (lb),
            .i_left_size  (ls),
            .i_right_base (rb),
            .i_right_size (rs),
            .o_wbase      (w_wbase[k]),
            .o_wsize      (w_wsize[k]),
            .o_cbase      (w_cbase[k]),
            .o_csize      (w_csize[k]),
            .o_less       (w_less[k]),
            .o_touch      (w_touch[k])
        );
    end

endmodule

// ===== rtl/core/flci_chk.sv =====
// Port checker for the free list block and its bind.
`include "free_list_insert_coalesce_assert.svh"

module flci_chk #(
    parameter int TABLE_DEPTH = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [flci_pkg::INDEX_W-1:0] out_index,
    input logic [flci_pkg::COUNT_W-1:0] out_count,
    input logic                         out_dropped,
    input logic                         out_last
);

    `FLCI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "entry lost while stalled")
    `FLCI_ASSERT_IMPL(a_last_index, out_valid && out_last, out_index == flci_pkg::INDEX_W'(out_count - 5'd1), "last entry index mismatch")
    `FLCI_ASSERT_IMPL(a_drop_full, out_valid && out_dropped, out_count == flci_pkg::COUNT_W'(TABLE_DEPTH), "drop with table not full")

endmodule

bind free_list_insert_coalesce flci_chk #(.TABLE_DEPTH(TABLE_DEPTH)) u_flci_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .out_valid   (o_entry.valid),
    .out_ready   (o_entry.ready),
    .out_index   (o_entry.entry_index),
    .out_count   (o_entry.entry_count),
    .out_dropped (o_entry.dropped),
    .out_last    (o_entry.last_entry)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the free list insert and coalesce block.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH   = 16;
    localparam int WD_MAX  = 3000;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    typedef struct {
        logic [31:0] base;
        logic [31:0] size;
        logic [3:0]  index;
        logic [4:0]  count;
        logic        dropped;
        logic        last;
    } t_entry;

    class free_list_scoreboard;
        logic [31:0]  bases [DEPTH+1];
        logic [31:0]  sizes [DEPTH+1];
        int           length;
        logic [2:0]   order;
        logic         merge_on;
        t_entry       dump_q[$];
        int           errors;
        int           frees;
        int           drops;
        int           entries_seen;

        function new();
            length = 0;
            order = flci_pkg::ORD_BACK;
            merge_on = 1'b0;
            errors = 0;
            frees = 0;
            drops = 0;
            entries_seen = 0;
        endfunction

        // Insert into a copy one deeper, coalesce if enabled, commit unless it overflows.
        function void note_free(logic [31:0] cb, logic [31:0] cs);
            logic [31:0] wb [DEPTH+1];
            logic [31:0] ws [DEPTH+1];
            int          n, pos, i, j, k;
            bit          less, found, drop;
            t_entry      e;
            wb = bases;
            ws = sizes;
            n = length;
            drop = 0;
            pos = n;
            if (order == flci_pkg::ORD_FRONT) begin
                pos = 0;
            end else if (order == flci_pkg::ORD_BASE_UP || order == flci_pkg::ORD_SIZE_UP ||
                         order == flci_pkg::ORD_SIZE_DN) begin
                for (pos = 0; pos < n; pos++) begin
                    if (order == flci_pkg::ORD_BASE_UP)
                        less = wb[pos] < cb;
                    else if (order == flci_pkg::ORD_SIZE_UP)
                        less = ws[pos] < cs;
                    else
                        less = ws[pos] > cs;
                    if (!less)
                        break;
                end
            end
            for (k = n; k > pos; k--) begin
                wb[k] = wb[k-1];
                ws[k] = ws[k-1];
            end
            wb[pos] = cb;
            ws[pos] = cs;
            n++;
            if (merge_on) begin
                i = 0;
                while (i < n) begin
                    found = 0;
                    for (j = 0; j < n && !found; j++) begin
                        if (j != i && wb[j] >= wb[i] && wb[j] - wb[i] == ws[i]) begin
                            ws[i] = (ws[j] > ALL_ONES - ws[i]) ? ALL_ONES : ws[i] + ws[j];
                            for (k = j; k + 1 < n; k++) begin
                                wb[k] = wb[k+1];
                                ws[k] = ws[k+1];
                            end
                            n--;
                            if (j < i)
                                i--;
                            found = 1;
                        end
                    end
                    if (!found)
                        i++;
                end
            end
            if (n > DEPTH) begin
                drop = 1;
                drops++;
            end else begin
                bases = wb;
                sizes = ws;
                length = n;
            end
            frees++;
            for (k = 0; k < length; k++) begin
                e.base = bases[k];
                e.size = sizes[k];
                e.index = k[3:0];
                e.count = length[4:0];
                e.dropped = drop;
                e.last = (k + 1 == length);
                dump_q = {dump_q, e};
            end
        endfunction

        function void check_entry(t_entry got);
            t_entry exp;
            entries_seen++;
            if (dump_q.size() == 0) begin
                $display("%0t: unexpected entry base=%h size=%h index=%0d", $time,
                         got.base, got.size, got.index);
                errors++;
                return;
            end
            exp = dump_q.pop_front();
            if (got.base !== exp.base) begin
                $display("%0t: entry_base expected %h actual %h", $time, exp.base, got.base);
                errors++;
            end
            if (got.size !== exp.size) begin
                $display("%0t: entry_size expected %h actual %h", $time, exp.size, got.size);
                errors++;
            end
            if (got.index !== exp.index) begin
                $display("%0t: entry_index expected %0d actual %0d", $time, exp.index,
                         got.index);
                errors++;
            end
            if (got.count !== exp.count) begin
                $display("%0t: entry_count expected %0d actual %0d", $time, exp.count,
                         got.count);
                errors++;
            end
            if (got.dropped !== exp.dropped) begin
                $display("%0t: dropped expected %b actual %b", $time, exp.dropped,
                         got.dropped);
                errors++;
            end
            if (got.last !== exp.last) begin
                $display("%0t: last_entry expected %b actual %b", $time, exp.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic            i_clk = 1'b0;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [0:0]      i_cfg_idx;
    logic [2:0]      i_cfg_data;
    flci_chunk_if    chunk();
    flci_entry_if    entry();

    free_list_scoreboard sb = new();
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    free_list_insert_coalesce uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_chunk    (chunk),
        .o_entry    (entry)
    );

    // Receiver: check each transfer, randomize ready, run the watchdog.
    always @(posedge i_clk) begin
        t_entry got;
        if (i_rst_n) begin
            if (entry.valid && entry.ready) begin
                got.base = entry.entry_base;
                got.size = entry.entry_size;
                got.index = entry.entry_index;
                got.count = entry.entry_count;
                got.dropped = entry.dropped;
                got.last = entry.last_entry;
                sb.check_entry(got);
            end
            if ((entry.valid && entry.ready) || (chunk.valid && chunk.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WD_MAX) begin
                $display("%0t: watchdog expired, %0d entries outstanding", $time,
                         sb.dump_q.size());
                $display("FAIL free_list_insert_coalesce");
                $finish;
            end
        end
        entry.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_config(logic [2:0] ord, logic mrg);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= flci_pkg::REG_INSERT_ORDER;
        i_cfg_data <= ord;
        @(posedge i_clk);
        i_cfg_idx <= flci_pkg::REG_MERGE_ENABLE;
        i_cfg_data <= {2'b00, mrg};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.order = ord;
        sb.merge_on = mrg;
    endtask

    // Leaves valid high after the transfer; the next call drives it again, the drain lowers it.
    task automatic send_chunk(logic [31:0] cb, logic [31:0] cs);
        if ($urandom_range(99) < send_idle_pct) begin
            chunk.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge i_clk);
        end
        chunk.valid <= 1'b1;
        chunk.chunk_base <= cb;
        chunk.chunk_size <= cs;
        @(posedge i_clk);
        while (!chunk.ready)
            @(posedge i_clk);
        sb.note_free(cb, cs);
    endtask

    task automatic drain();
        chunk.valid <= 1'b0;
        while (sb.dump_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Mostly aligned chunks in a small arena so neighbors touch; the rest is noise.
    task automatic send_random();
        logic [31:0] cb, cs;
        if ($urandom_range(99) < 80) begin
            cb = 32'd16 * $urandom_range(0, 63);
            cs = 32'd16 * $urandom_range(1, 4);
        end else begin
            cb = $urandom();
            cs = $urandom();
            if ($urandom_range(9) == 0)
                cs = ALL_ONES;
            if (cs == 0)
                cs = 32'd1;
        end
        send_chunk(cb, cs);
    endtask

    initial begin
        logic [2:0] ord;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= flci_pkg::REG_INSERT_ORDER;
        i_cfg_data <= '0;
        chunk.valid <= 1'b0;
        chunk.chunk_base <= '0;
        chunk.chunk_size <= '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, saturation, no wrap past the top of the space.
        write_config(flci_pkg::ORD_BASE_UP, 1'b1);
        send_chunk(32'h0000_0000, ALL_ONES);
        send_chunk(ALL_ONES, 32'd5);
        send_chunk(32'hFFFF_FFF0, 32'h20);
        send_chunk(32'h0000_0010, 32'd1);
        send_chunk(32'h0000_0020, 32'h10);
        send_chunk(32'h0000_0030, 32'h8);
        send_chunk(32'h0000_0011, 32'hF);
        drain();
        write_config(flci_pkg::ORD_SIZE_UP, 1'b0);
        for (int k = 0; k < 6; k++)
            send_chunk(32'h1000 + 32'h100 * k, 32'h40 - 32'h8 * k);
        drain();
        write_config(flci_pkg::ORD_SIZE_DN, 1'b1);
        for (int k = 0; k < 6; k++)
            send_chunk(32'h8000 + 32'h10 * k, 32'h10);
        drain();
        write_config(flci_pkg::ORD_FRONT, 1'b0);
        send_chunk(32'h7000, 32'h1);
        send_chunk(32'h7100, 32'h2);
        drain();
        write_config(3'd7, 1'b1);
        send_chunk(32'h8060, 32'h10);
        drain();

        // Random phases across all order codes, both merge settings and all idle modes.
        for (int p = 0; p < 12; p++) begin
            ord = p[2:0];
            write_config(ord, p % 3 != 0);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            for (int k = 0; k < 25; k++)
                send_random();
            drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        $display("Covered %0d frees (%0d refused as full), %0d list entries checked,",
                 sb.frees, sb.drops, sb.entries_seen);
        $display("all insert orders, merging on and off, with idle and stall phases.");
        if (sb.errors == 0 && sb.dump_q.size() == 0)
            $display("PASS free_list_insert_coalesce");
        else
            $display("FAIL free_list_insert_coalesce");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/flci_pkg.sv
rtl/core/flci_chunk_if.sv
rtl/core/flci_entry_if.sv
rtl/core/flci_cell.sv
rtl/core/free_list_insert_coalesce.sv
rtl/core/flci_chk.sv
tb/testbench.sv
